@@ design/rmd_pkg.sv @@
// ----------------------------------------------------------------------------
// rmd_pkg: shared types and constants for the RTP media depacketizer
// Result record, configuration record, result kinds, register indexes and
// the fixed header offsets of RTP and RFC 4175 packets.
// ----------------------------------------------------------------------------
package rmd_pkg;

	// result kinds
	localparam logic [1:0] KIND_VWRITE = 2'd0;
	localparam logic [1:0] KIND_ABYTE  = 2'd1;
	localparam logic [1:0] KIND_VDONE  = 2'd2;
	localparam logic [1:0] KIND_ADONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_AUDIO_MODE   = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_LINE_STRIDE  = 2'd2;

	// register reset values
	localparam logic [14:0] RESET_HEIGHT = 15'd1080;
	localparam logic [15:0] RESET_STRIDE = 16'd7680;

	// header layout: RTP fixed header, then RFC 4175 segment header
	localparam logic [15:0] RTP_HDR     = 16'd12;
	localparam logic [15:0] VID_HDR     = 16'd20;
	localparam logic [15:0] POS_MARKER  = 16'd1;
	localparam logic [15:0] POS_TS_FIRST = 16'd4;
	localparam logic [15:0] POS_TS_LAST = 16'd7;
	localparam logic [15:0] POS_LEN_HI  = 16'd14;
	localparam logic [15:0] POS_LEN_LO  = 16'd15;
	localparam logic [15:0] POS_LINE_HI = 16'd16;
	localparam logic [15:0] POS_LINE_LO = 16'd17;
	localparam logic [15:0] POS_OFF_HI  = 16'd18;
	localparam logic [15:0] POS_OFF_LO  = 16'd19;
	localparam int          MARKER_BIT  = 7;

	// divide by six through reciprocal multiply
	localparam logic [16:0] RECIP6_16 = 17'h0AAAB;  // x/6 = (x*RECIP6_16) >> 18
	localparam int          SHIFT6_16 = 18;
	localparam logic [31:0] RECIP6_31 = 32'hAAAAAAAB; // x/6 = (x*RECIP6_31) >> 34
	localparam int          SHIFT6_31 = 34;

	// result queue
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic        audio_mode;
		logic [14:0] frame_height;
		logic [15:0] line_stride;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] address;
		logic [7:0]  payload_byte;
		logic [7:0]  frame_number;
		logic [31:0] timestamp;
		logic [13:0] sample_count;
		logic        last_of_run;
	} result_t;

	// up to two results from one request
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

@@ design/rtp_media_depacketizer.sv @@
// ----------------------------------------------------------------------------
// rtp_media_depacketizer: RTP video / audio depacketizer
// Turns RTP packet bytes into frame buffer writes (RFC 4175 video) or
// whole 24-bit stereo samples (audio), with completion results.
//
//   channel | direction | handshake              | content
//   s_axis  | in        | tvalid/tready          | one packet byte, length, tlast
//   m_axis  | out       | tvalid/tready          | one result, kind in tuser
//   cfg     | in        | cfg_we, no wait        | mode, frame height, line stride
//
// Each byte is registered, parsed and its results queued; a byte is
// accepted every cycle while the four-entry result queue has room for two.
// The final byte of a packet can yield two results, which leave the queue
// one at a time; each result passes the input register and the result queue.
// Reset clears all control and packet state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rtp_media_depacketizer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// packet bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] packet_bytes
	input  logic        s_axis_tlast,  // last_byte
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [30:0] address, [38:31] payload_byte, [46:39] frame_number,
	// [78:47] timestamp, [92:79] sample_count, [95:93] zero
	output logic [95:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast   // last_of_run
);
	import rmd_pkg::*;

	cfg_t    cfg_q;
	push_t   push;
	logic    room;
	result_t out_res;
	logic [$clog2(QDEPTH+1)-1:0] level;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.audio_mode   <= 1'b0;
			cfg_q.frame_height <= RESET_HEIGHT;
			cfg_q.line_stride  <= RESET_STRIDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AUDIO_MODE:   cfg_q.audio_mode   <= cfg_data[0];
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[14:0];
				CFG_LINE_STRIDE:  cfg_q.line_stride  <= cfg_data;
				default: ;
			endcase
		end
	end

	rmd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata[7:0]),
		.in_plen  (s_axis_tdata[23:8]),
		.in_last  (s_axis_tlast),
		.room     (room),
		.push     (push)
	);

	rmd_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.level     (level)
	);

	// pack the result
	assign m_axis_tdata = {3'b000, out_res.sample_count, out_res.timestamp,
	                       out_res.frame_number, out_res.payload_byte, out_res.address};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last_of_run;

	// queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= ($clog2(QDEPTH+1))'(QDEPTH))
		else $error("result queue overflow");

	// a second result is always a completion and closes the run
	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r1.last_of_run && !push.r0.last_of_run &&
		(push.r1.kind == KIND_VDONE || push.r1.kind == KIND_ADONE))
		else $error("bad result pair");

	// a pair starts with a byte result
	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> (push.r0.kind == KIND_VWRITE || push.r0.kind == KIND_ABYTE))
		else $error("pair without byte result");

endmodule

@@ design/rmd_parser.sv @@
// ----------------------------------------------------------------------------
// rmd_parser: packet byte parser
// Input register, header capture, segment and sample decisions, and the
// one or two results that each byte causes.
// ----------------------------------------------------------------------------
module rmd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  rmd_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_data,
	input  logic [15:0]   in_plen,
	input  logic          in_last,
	input  logic          room,
	output rmd_pkg::push_t push
);
	import rmd_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic [15:0] plen_s1;
	logic        last_s1;

	// packet state
	logic [15:0] pos_q;
	logic        marker_q;
	logic [31:0] ts_q;
	logic [15:0] len_q;
	logic [14:0] line_q;
	logic [14:0] off_q;
	logic [30:0] waddr_q;
	logic [15:0] btc_q;
	logic        pv_q;
	logic [7:0]  frame_q;

	// next values
	logic        adv;
	logic        marker_nx;
	logic [31:0] ts_nx;
	logic [15:0] len_nx;
	logic [14:0] line_nx;
	logic [14:0] off_nx;
	logic [30:0] waddr_mid;
	logic [15:0] btc_mid;
	logic        pv_mid;
	logic [30:0] waddr_nx;
	logic [15:0] btc_nx;
	logic        pv_nx;
	logic [15:0] pos_nx;
	logic [7:0]  frame_nx;

	// decision arithmetic
	logic [15:0] maxc;
	logic [15:0] copy;
	logic [30:0] line_prod;
	logic [31:0] vaddr_sum;
	logic [15:0] alen;
	logic [32:0] alen_prod;
	logic [13:0] samples;
	logic [62:0] q_prod;
	logic [13:0] done_samples;

	logic        emit;
	logic        complete;
	logic        done_emit;
	result_t     wres;
	result_t     dres;

	assign in_ready = !valid_s1 || room;
	assign adv      = valid_s1 && room;

	// load a new byte or drain the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
			plen_s1 <= in_plen;
			last_s1 <= in_last;
		end
	end

	// header capture
	always_comb begin
		marker_nx = (pos_q == POS_MARKER) ? data_s1[MARKER_BIT] : marker_q;
		ts_nx     = (pos_q >= POS_TS_FIRST && pos_q <= POS_TS_LAST) ?
		            {ts_q[23:0], data_s1} : ts_q;
		len_nx    = len_q;
		line_nx   = line_q;
		off_nx    = off_q;
		if (pos_q == POS_LEN_HI)  len_nx  = {data_s1, 8'h00};
		if (pos_q == POS_LEN_LO)  len_nx  = {len_q[15:8], data_s1};
		if (pos_q == POS_LINE_HI) line_nx = {data_s1[6:0], 8'h00};
		if (pos_q == POS_LINE_LO) line_nx = {line_q[14:8], data_s1};
		if (pos_q == POS_OFF_HI)  off_nx  = {data_s1[6:0], 8'h00};
		if (pos_q == POS_OFF_LO)  off_nx  = {off_q[14:8], data_s1};
	end

	// segment decision: clamp to the line, drop lines past the frame
	always_comb begin
		maxc = (cfg.line_stride > {1'b0, off_nx}) ?
		       16'(cfg.line_stride - {1'b0, off_nx}) : 16'd0;
		copy = (len_nx < maxc) ? len_nx : maxc;
		if (line_nx >= cfg.frame_height) copy = 16'd0;
		line_prod = {16'd0, line_nx} * {15'd0, cfg.line_stride};
		vaddr_sum = {1'b0, line_prod} + {17'd0, off_nx};
	end

	// sample decision: whole six-byte samples only
	always_comb begin
		alen      = (plen_s1 >= RTP_HDR) ? 16'(plen_s1 - RTP_HDR) : 16'd0;
		alen_prod = {17'd0, alen} * {16'd0, RECIP6_16};
		samples   = alen_prod[SHIFT6_16 +: 14];
	end

	// per-byte work and results
	always_comb begin
		waddr_mid = waddr_q;
		btc_mid   = btc_q;
		pv_mid    = pv_q;
		emit      = 1'b0;
		if (!cfg.audio_mode) begin
			if (pos_q == VID_HDR - 16'd1) begin
				pv_mid    = ({1'b0, plen_s1} >= {1'b0, VID_HDR} + {1'b0, len_nx});
				waddr_mid = vaddr_sum[30:0];
				btc_mid   = copy;
			end else if (pos_q >= VID_HDR && pv_q && btc_q != 16'd0) begin
				emit      = 1'b1;
				waddr_mid = 31'(waddr_q + 31'd1);
				btc_mid   = 16'(btc_q - 16'd1);
			end
		end else begin
			if (pos_q == RTP_HDR - 16'd1) begin
				pv_mid    = (samples != 14'd0);
				btc_mid   = {samples, 2'b00} + {1'b0, samples, 1'b0};
				waddr_mid = 31'd0;
			end else if (pos_q >= RTP_HDR && pv_q && btc_q != 16'd0) begin
				emit      = 1'b1;
				waddr_mid = 31'(waddr_q + 31'd1);
				btc_mid   = 16'(btc_q - 16'd1);
			end
		end

		// completion only when the last flag lands on the declared length
		complete  = last_s1 && pv_mid && ({1'b0, pos_q} + 17'd1 == {1'b0, plen_s1});
		done_emit = complete && (cfg.audio_mode || marker_nx);

		q_prod       = {32'd0, waddr_mid} * {31'd0, RECIP6_31};
		done_samples = q_prod[SHIFT6_31 +: 14];

		wres.kind         = cfg.audio_mode ? KIND_ABYTE : KIND_VWRITE;
		wres.address      = waddr_q;
		wres.payload_byte = data_s1;
		wres.frame_number = frame_q;
		wres.timestamp    = ts_nx;
		wres.sample_count = 14'd0;
		wres.last_of_run  = !done_emit;

		dres.kind         = cfg.audio_mode ? KIND_ADONE : KIND_VDONE;
		dres.address      = 31'd0;
		dres.payload_byte = 8'd0;
		dres.frame_number = frame_q;
		dres.timestamp    = ts_nx;
		dres.sample_count = cfg.audio_mode ? done_samples : 14'd0;
		dres.last_of_run  = 1'b1;

		push.n  = adv ? (2'({1'b0, emit}) + 2'({1'b0, done_emit})) : 2'd0;
		push.r0 = emit ? wres : dres;
		push.r1 = dres;

		// end of packet clears the position, validity and byte count
		frame_nx = (done_emit && !cfg.audio_mode) ? 8'(frame_q + 8'd1) : frame_q;
		waddr_nx = waddr_mid;
		if (last_s1) begin
			pos_nx = 16'd0;
			pv_nx  = 1'b0;
			btc_nx = 16'd0;
		end else begin
			pos_nx = (pos_q != 16'hFFFF) ? 16'(pos_q + 16'd1) : pos_q;
			pv_nx  = pv_mid;
			btc_nx = btc_mid;
		end
	end

	// advance packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			marker_q <= 1'b0;
			ts_q     <= '0;
			len_q    <= '0;
			line_q   <= '0;
			off_q    <= '0;
			waddr_q  <= '0;
			btc_q    <= '0;
			pv_q     <= 1'b0;
			frame_q  <= '0;
		end else if (adv) begin
			pos_q    <= pos_nx;
			marker_q <= marker_nx;
			ts_q     <= ts_nx;
			len_q    <= len_nx;
			line_q   <= line_nx;
			off_q    <= off_nx;
			waddr_q  <= waddr_nx;
			btc_q    <= btc_nx;
			pv_q     <= pv_nx;
			frame_q  <= frame_nx;
		end
	end

endmodule

@@ design/rmd_out_q.sv @@
// ----------------------------------------------------------------------------
// rmd_out_q: result queue
// Small queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module rmd_out_q (
	input  logic             clk,
	input  logic             arst_n,
	input  rmd_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output rmd_pkg::result_t out_res,
	output logic [$clog2(rmd_pkg::QDEPTH+1)-1:0] level
);
	import rmd_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int LVL_W = $clog2(QDEPTH + 1);

	result_t            mem [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LVL_W-1:0]   level_q;
	logic               pop;

	assign out_valid = (level_q != '0);
	assign out_res   = mem[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = (level_q <= LVL_W'(QDEPTH - 2));
	assign level     = level_q;

	// store pushed results
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2) mem[PTR_W'(wr_ptr_q + PTR_W'(1))] <= push.r1;
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(push.n));
			if (pop) rd_ptr_q <= PTR_W'(rd_ptr_q + PTR_W'(1));
			level_q <= LVL_W'(level_q + LVL_W'(push.n) - LVL_W'(pop));
		end
	end

endmodule

@@ tb/rtp_media_depacketizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_media_depacketizer_tb: self-checking bench for the RTP depacketizer
// Streams RTP video and audio packets byte by byte, predicts every frame
// write, audio byte and completion in a bit-exact model of the parser, and
// compares each result request against the oldest prediction. Directed
// packets cover header decoding, clamping, short, mismatched and long
// packets; random phases mix well-formed packets with noise, most of them
// under random back-pressure on both sides.
// ----------------------------------------------------------------------------
module rtp_media_depacketizer_tb;
	import rmd_pkg::*;

	localparam int unsigned SAMPLE_BYTES  = 6;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          MAX_REPORTS   = 10;
	localparam int          RANDOM_BYTES  = 120;
	localparam int          PHASES        = 6;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = CFG_AUDIO_MODE;
	logic [15:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	rtp_media_depacketizer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// parser state of the prediction, at reset values
	cfg_t        cfg_now      = '{1'b0, RESET_HEIGHT, RESET_STRIDE};
	logic [15:0] rx_pos       = '0;
	logic        rx_marker    = 1'b0;
	logic [31:0] rx_timestamp = '0;
	logic [15:0] seg_length   = '0;
	logic [14:0] seg_line     = '0;
	logic [14:0] seg_offset   = '0;
	logic [30:0] wr_addr      = '0;
	logic [15:0] copy_left    = '0;
	logic        pkt_ok       = 1'b0;
	logic [7:0]  frame_no     = '0;

	result_t     expected_results[$];
	logic [7:0]  pkt[$];
	int          error_count = 0;
	int          bytes_sent  = 0;
	bit          send_gaps   = 1'b1;
	bit          sink_gaps   = 1'b1;
	int          hold_req    = 0;
	int          hold_ack    = 0;
	int          hold_left   = 0;
	result_t     got;
	result_t     want;

	function automatic result_t make_result(input logic [1:0] kind, input logic [30:0] addr,
	                                        input logic [7:0] data, input logic [13:0] samples);
		result_t r;
		r.kind         = kind;
		r.address      = addr;
		r.payload_byte = data;
		r.frame_number = frame_no;
		r.timestamp    = rx_timestamp;
		r.sample_count = samples;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	// advance the parser by one accepted byte and queue the results it causes
	task automatic predict_byte(input logic [7:0] d, input logic [15:0] plen, input logic last);
		result_t     r [2];
		int          n;
		int          i;
		int unsigned room;
		int unsigned copy;
		int unsigned samples;
		n = 0;
		if (rx_pos == POS_MARKER)
			rx_marker = d[MARKER_BIT];
		if (rx_pos >= POS_TS_FIRST && rx_pos <= POS_TS_LAST)
			rx_timestamp = {rx_timestamp[23:0], d};
		case (rx_pos)
			POS_LEN_HI:  seg_length = {d, 8'h00};
			POS_LEN_LO:  seg_length[7:0] = d;
			POS_LINE_HI: seg_line = {d[6:0], 8'h00};
			POS_LINE_LO: seg_line[7:0] = d;
			POS_OFF_HI:  seg_offset = {d[6:0], 8'h00};
			POS_OFF_LO:  seg_offset[7:0] = d;
			default: ;
		endcase

		if (!cfg_now.audio_mode) begin
			// decide the segment at the end of the video header
			if (rx_pos == VID_HDR - 16'd1) begin
				room = (cfg_now.line_stride > seg_offset) ? cfg_now.line_stride - seg_offset : 0;
				copy = (seg_length < room) ? seg_length : room;
				if (seg_line >= cfg_now.frame_height)
					copy = 0;
				pkt_ok    = (32'(plen) >= 32'(VID_HDR) + 32'(seg_length));
				wr_addr   = 31'(32'(seg_line) * 32'(cfg_now.line_stride) + 32'(seg_offset));
				copy_left = 16'(copy);
			end else if (rx_pos >= VID_HDR && pkt_ok && copy_left != 0) begin
				r[n] = make_result(KIND_VWRITE, wr_addr, d, '0);
				n++;
				wr_addr++;
				copy_left--;
			end
		end else begin
			// size the audio block at the end of the RTP header
			if (rx_pos == RTP_HDR - 16'd1) begin
				samples   = (plen >= RTP_HDR) ? (32'(plen) - 32'(RTP_HDR)) / SAMPLE_BYTES : 0;
				pkt_ok    = (samples != 0);
				copy_left = 16'(samples * SAMPLE_BYTES);
				wr_addr   = '0;
			end else if (rx_pos >= RTP_HDR && pkt_ok && copy_left != 0) begin
				r[n] = make_result(KIND_ABYTE, wr_addr, d, '0);
				n++;
				wr_addr++;
				copy_left--;
			end
		end

		if (last) begin
			// complete only when the flag lands on the declared final byte
			if (pkt_ok && 32'(rx_pos) + 1 == 32'(plen)) begin
				if (!cfg_now.audio_mode) begin
					if (rx_marker) begin
						r[n] = make_result(KIND_VDONE, '0, '0, '0);
						n++;
						frame_no++;
					end
				end else begin
					r[n] = make_result(KIND_ADONE, '0, '0, 14'(wr_addr / SAMPLE_BYTES));
					n++;
				end
			end
			rx_pos    = '0;
			pkt_ok    = 1'b0;
			copy_left = '0;
		end else if (rx_pos != 16'hFFFF) begin
			rx_pos++;
		end

		if (n > 0)
			r[n - 1].last_of_run = 1'b1;
		for (i = 0; i < n; i++)
			expected_results.push_back(r[i]);
	endtask

	// offer one byte, with random gaps, and predict it once accepted
	task automatic send_byte(input logic [7:0] d, input logic [15:0] plen, input logic last);
		while (send_gaps && $urandom_range(0, 99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {plen, d};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_byte(d, plen, last);
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [15:0] plen);
		foreach (pkt[i])
			send_byte(pkt[i], plen, i == pkt.size() - 1);
	endtask

	task automatic send_whole();
		send_packet(16'(pkt.size()));
	endtask

	// stop offering and wait for every predicted result
	task automatic pause_until_done();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// let bytes that cause no result leave the pipeline too
	task automatic settle();
		pause_until_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_AUDIO_MODE:   cfg_now.audio_mode = value[0];
			CFG_FRAME_HEIGHT: cfg_now.frame_height = value[14:0];
			CFG_LINE_STRIDE:  cfg_now.line_stride = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic mode, input logic [14:0] height,
	                          input logic [15:0] stride);
		settle();
		write_reg(CFG_AUDIO_MODE, {15'd0, mode});
		write_reg(CFG_FRAME_HEIGHT, {1'b0, height});
		write_reg(CFG_LINE_STRIDE, stride);
		cfg_we <= 1'b0;
	endtask

	// RTP fixed header: version, marker and type, sequence, timestamp, source
	task automatic put_rtp_header(input logic marker);
		logic [31:0] ts;
		ts = $urandom;
		pkt.delete();
		pkt.push_back(8'h80);
		pkt.push_back({marker, 7'($urandom)});
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(ts[31:24]);
		pkt.push_back(ts[23:16]);
		pkt.push_back(ts[15:8]);
		pkt.push_back(ts[7:0]);
		repeat (4) pkt.push_back(8'($urandom));
	endtask

	task automatic put_payload(input int n);
		repeat (n) pkt.push_back(8'($urandom));
	endtask

	// RFC 4175 packet; the bits above line and offset are random
	task automatic build_video(input logic marker, input int len, input int line,
	                           input int off, input int n);
		logic [15:0] l16;
		logic [14:0] ln;
		logic [14:0] of;
		l16 = 16'(len);
		ln  = 15'(line);
		of  = 15'(off);
		put_rtp_header(marker);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(l16[15:8]);
		pkt.push_back(l16[7:0]);
		pkt.push_back({1'($urandom), ln[14:8]});
		pkt.push_back(ln[7:0]);
		pkt.push_back({1'($urandom), of[14:8]});
		pkt.push_back(of[7:0]);
		put_payload(n);
	endtask

	task automatic build_audio(input int n);
		put_rtp_header(1'($urandom));
		put_payload(n);
	endtask

	// drive the result ready: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= sink_gaps ? ($urandom_range(0, 99) >= 36) : 1'b1;
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind         = m_axis_tuser;
			got.address      = m_axis_tdata[30:0];
			got.payload_byte = m_axis_tdata[38:31];
			got.frame_number = m_axis_tdata[46:39];
			got.timestamp    = m_axis_tdata[78:47];
			got.sample_count = m_axis_tdata[92:79];
			got.last_of_run  = m_axis_tlast;
			if (expected_results.size() == 0) begin
				want = '0;
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected result: kind=%0d addr=%h byte=%h frame=%0d",
					         got.kind, got.address, got.payload_byte, got.frame_number);
			end else begin
				want = expected_results.pop_front();
				if (got != want) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("mismatch: exp kind=%0d addr=%h byte=%h frame=%0d ts=%h n=%0d last=%b",
						         want.kind, want.address, want.payload_byte, want.frame_number,
						         want.timestamp, want.sample_count, want.last_of_run);
						$display("          got kind=%0d addr=%h byte=%h frame=%0d ts=%h n=%0d last=%b",
						         got.kind, got.address, got.payload_byte, got.frame_number,
						         got.timestamp, got.sample_count, got.last_of_run);
					end
				end
			end
		end
	end

	// writes, clamping, line limit, frame end, short and mismatched packets
	task automatic test_video_basic();
		set_config(1'b0, 15'd4, 16'd16);
		build_video(1'b0, 6, 1, 2, 6);
		send_whole();
		build_video(1'b1, 4, 2, 0, 4);
		send_whole();
		// clamp to the end of the line
		build_video(1'b0, 8, 0, 12, 8);
		send_whole();
		// offset past the line: no writes
		build_video(1'b0, 4, 0, 16, 4);
		send_whole();
		// empty segment still ends the frame
		build_video(1'b1, 0, 3, 0, 0);
		send_whole();
		// line outside the frame: frame ends, nothing written
		build_video(1'b1, 4, 4, 0, 4);
		send_whole();
		// short packet: ends before the segment header is complete
		build_video(1'b1, 4, 0, 0, 4);
		repeat (5) void'(pkt.pop_back());
		send_packet(16'd24);
		// declared length too long: writes but no frame end
		build_video(1'b1, 4, 0, 0, 4);
		send_packet(16'(pkt.size() + 3));
		// declared length below the segment: packet dropped
		build_video(1'b1, 4, 0, 0, 4);
		send_packet(16'd21);
		build_video(1'b1, 2, 0, 0, 2);
		send_packet(16'd0);
		build_video(1'b1, 2, 0, 0, 2);
		send_packet(16'hFFFF);
		build_video(1'b1, 2, 1, 0, 0);
		pkt.push_back(8'h00);
		pkt.push_back(8'hFF);
		send_whole();
	endtask

	// largest geometry, and zero or unit stride and height
	task automatic test_video_extremes();
		set_config(1'b0, 15'h7FFF, 16'hFFFF);
		build_video(1'b1, 3, 32766, 32767, 3);
		send_whole();
		build_video(1'b1, 3, 32767, 32767, 3);
		send_whole();
		set_config(1'b0, 15'd0, 16'd16);
		build_video(1'b1, 3, 0, 0, 3);
		send_whole();
		set_config(1'b0, 15'd4, 16'd0);
		build_video(1'b1, 3, 0, 0, 3);
		send_whole();
		set_config(1'b0, 15'd1, 16'd1);
		build_video(1'b1, 5, 0, 0, 5);
		send_whole();
	endtask

	// whole samples, leftover bytes, empty and short blocks
	task automatic test_audio_basic();
		set_config(1'b1, 15'd4, 16'd16);
		build_audio(15);
		send_whole();
		build_audio(6);
		send_whole();
		build_audio(5);
		send_whole();
		build_audio(0);
		send_whole();
		build_audio(6);
		repeat (10) void'(pkt.pop_back());
		send_packet(16'd18);
		build_audio(12);
		send_packet(16'(pkt.size() + 1));
		build_audio(6);
		send_packet(16'hFFFF);
	endtask

	// a long packet and a short one, sent back to back with no idling
	task automatic test_long_packet();
		send_gaps = 1'b0;
		sink_gaps <= 1'b0;
		set_config(1'b0, 15'd8, 16'd64);
		build_video(1'b1, 40, 0, 0, 40);
		send_whole();
		build_video(1'b1, 3, 1, 0, 3);
		send_whole();
		send_gaps = 1'b1;
	endtask

	// hold the result side off until the input stalls, then drain and resume
	task automatic test_backpressure();
		set_config(1'b0, 15'd8, 16'd256);
		sink_gaps <= 1'b1;
		hold_req <= hold_req + 1;
		repeat (3) begin
			build_video(1'($urandom), 20, $urandom_range(0, 7), $urandom_range(0, 100), 20);
			send_whole();
		end
		pause_until_done();
		build_video(1'b1, 10, 2, 5, 10);
		send_whole();
	endtask

	// mostly well-formed packets, some with bad lengths, early ends or junk
	task automatic random_packet();
		int          pick;
		int          n;
		int          len;
		int          line;
		int          off;
		int          lim;
		logic [15:0] plen;
		pick = $urandom_range(0, 99);
		n = $urandom_range(0, 24);
		if (cfg_now.audio_mode) begin
			build_audio(n);
		end else begin
			lim  = (cfg_now.frame_height < 15'h7FFF) ? cfg_now.frame_height + 1 : 32767;
			line = $urandom_range(0, lim);
			off  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 8);
			len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n + 8) : n;
			build_video($urandom_range(0, 2) == 0, len, line, off, n);
		end
		plen = 16'(pkt.size());
		if (pick < 80) begin
			send_whole();
		end else if (pick < 88) begin
			if ($urandom_range(0, 3) == 0)
				send_packet(16'($urandom));
			else
				send_packet(16'(pkt.size() + $urandom_range(0, 4) - 2));
		end else if (pick < 94) begin
			repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
			send_packet(plen);
		end else begin
			pkt.delete();
			put_payload($urandom_range(1, 24));
			send_packet(16'($urandom_range(0, 40)));
		end
	endtask

	task automatic test_random_traffic();
		int          ph;
		int          target;
		logic [14:0] height;
		logic [15:0] stride;
		for (ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0:       height = 15'd1;
				1:       height = 15'h7FFF;
				default: height = 15'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 3))
				0:       stride = 16'd1;
				1:       stride = 16'hFFFF;
				default: stride = 16'($urandom_range(1, 64));
			endcase
			set_config(ph % 3 == 2, height, stride);
			send_gaps = (ph != 3);
			sink_gaps <= (ph != 3);
			target = bytes_sent + RANDOM_BYTES / PHASES;
			while (bytes_sent < target)
				random_packet();
		end
		send_gaps = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_video_basic();
		test_video_extremes();
		test_audio_basic();
		test_long_packet();
		test_backpressure();
		test_random_traffic();
		settle();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// give up on a hung run
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
